@@ sv/sound_channel_allocator_assert.svh @@
// assertion macros for the sound channel allocator, clocked on clk_i, reset by rst_ni
`ifndef SOUND_CHANNEL_ALLOCATOR_ASSERT_SVH
`define SOUND_CHANNEL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sound channel allocator check failed");
`define SCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sound channel allocator check failed");
`else
`define SCA_ASSERT_IMP(lbl, ante, cons)
`define SCA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ sv/sca_pkg.sv @@
`timescale 1ns / 1ps

package sca_pkg;

  // request operations
  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_STOP     = 2'd1,
    OP_TICK     = 2'd2,
    OP_STOP_ALL = 2'd3
  } op_e;

  // channel index as carried along the chain, enough for 32 channels
  localparam int unsigned ChanIdxW = 5;

  // request as latched by the controller and broadcast to every cell
  typedef struct packed {
    logic        en;
    op_e         op;
    logic [15:0] origin;
    logic [7:0]  sound;
    logic [7:0]  prio;
    logic [15:0] dur;
    logic        pickup;
  } req_t;

  // controller strobes to all cells
  typedef struct packed {
    logic        clr;
    logic        commit;
    logic        use_free;
    logic [31:0] tick;
  } ctl_t;

  // scan token and search carries handed from cell to cell
  typedef struct packed {
    logic                tok;
    logic                hit1;
    logic                hit2;
    logic                hit3;
    logic [ChanIdxW-1:0] idx2;
    logic [ChanIdxW-1:0] idx3;
  } link_t;

endpackage

@@ sv/sound_channel_allocator.sv @@
`timescale 1ns / 1ps

// Sound channel allocator: keeps NUM_CHANNELS sound channels and serves one
// request at a time (start, stop by origin, tick, stop all), answering every
// request with exactly one result (grant flag, channel, freed and active masks;
// masks cover channels 0 to 7, channel numbers are reported modulo 8).
// The channels sit in a row of cells; a scan token walks the row one cell per
// clock. Between acceptance and the next acceptance a request passes these
// steps: the token is launched and crosses the row, a commit step writes the
// granted channel, and a write step loads the result register once it is
// free; no new request is taken before that.
// The result register lets a finished result wait for the consumer while the
// next request is already taken. With sound_enable low every request is
// answered with no grant, nothing freed and the current active mask, and the
// tick count holds. The config port is always ready; write it only between
// requests.
module sound_channel_allocator import sca_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] origin_id_i,
  input  logic [7:0]  sound_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] duration_i,
  input  logic        is_pickup_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        granted_o,
  output logic [2:0]  channel_o,
  output logic [7:0]  freed_mask_o,
  output logic [7:0]  active_mask_o,
  // sound_enable register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  `include "sound_channel_allocator_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_WRITE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                en_q;
  logic [31:0]         tick_q;
  req_t                req_q;
  logic                go_q;
  logic                hit2_q;
  logic                hit3_q;
  logic [ChanIdxW-1:0] idx_q;

  logic                out_valid_q;
  logic                granted_q;
  logic [2:0]          channel_q;
  logic [7:0]          freed_mask_q;
  logic [7:0]          active_mask_q;

  logic                in_acc;
  logic                out_load;
  logic                grant;
  ctl_t                ctl;
  link_t               links [NUM_CHANNELS+1];
  logic [NUM_CHANNELS-1:0] cell_act;
  logic [NUM_CHANNELS-1:0] cell_freed;
  logic [7:0]          act_mask;
  logic [7:0]          freed_mask;
  link_t               tail;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);
  assign tail        = links[NUM_CHANNELS];
  assign grant       = req_q.en && (req_q.op == OP_START) && (hit2_q || hit3_q);

  // token into the first cell, search carries start empty
  always_comb begin
    links[0]      = '0;
    links[0].tok  = go_q;
    ctl.clr       = in_acc;
    ctl.commit    = (state_q == ST_COMMIT) && req_q.en && (req_q.op == OP_START);
    ctl.use_free  = hit2_q;
    ctl.tick      = tick_q;
  end

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_cell
    sca_cell #(
      .CHAN_IDX (c)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req_q),
      .ctl_i    (ctl),
      .link_i   (links[c]),
      .link_o   (links[c+1]),
      .active_o (cell_act[c]),
      .freed_o  (cell_freed[c])
    );
  end

  // masks show channels 0 to 7 only
  for (genvar k = 0; k < 8; k++) begin : g_mask
    if (k < NUM_CHANNELS) begin : g_used
      assign act_mask[k]   = cell_act[k];
      assign freed_mask[k] = cell_freed[k];
    end else begin : g_none
      assign act_mask[k]   = 1'b0;
      assign freed_mask[k] = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.tok) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b1;
      tick_q      <= 32'd0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= in_acc;
      if (cfg_valid_i && cfg_ready_o) begin
        en_q <= cfg_data_i;
      end
      // tick count advances before the expiry scan sees it
      if (in_acc && en_q && (op_e'(operation_i) == OP_TICK)) begin
        tick_q <= tick_q + 32'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q.en     <= en_q;
      req_q.op     <= op_e'(operation_i);
      req_q.origin <= origin_id_i;
      req_q.sound  <= sound_id_i;
      req_q.prio   <= priority_req_i;
      req_q.dur    <= duration_i;
      req_q.pickup <= is_pickup_i;
    end
    // search outcome as the token leaves the last cell
    if ((state_q == ST_SCAN) && tail.tok) begin
      hit2_q <= tail.hit2;
      hit3_q <= tail.hit3;
      idx_q  <= tail.hit2 ? tail.idx2 : tail.idx3;
    end
    if (out_load) begin
      granted_q     <= grant;
      channel_q     <= grant ? idx_q[2:0] : 3'd0;
      freed_mask_q  <= freed_mask;
      active_mask_q <= act_mask;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign granted_o     = granted_q;
  assign channel_o     = channel_q;
  assign freed_mask_o  = freed_mask_q;
  assign active_mask_o = active_mask_q;

  // the token leaves the row only during a scan
  `SCA_ASSERT_IMP(a_tail_in_scan, tail.tok, state_q == ST_SCAN)
  // a new result appears only from the write step
  `SCA_ASSERT_NXT(a_load_from_write, !out_valid_q && (state_q != ST_WRITE), !out_valid_q)
  // without a grant nothing freed can be active again
  `SCA_ASSERT_IMP(a_no_regrant, out_valid_o && !granted_o, (freed_mask_o & active_mask_o) == 8'd0)
  // at most one channel is freed and retaken by one request
  `SCA_ASSERT_IMP(a_one_retake, out_valid_o, $countones(freed_mask_o & active_mask_o) <= 1)

endmodule

@@ sv/sca_cell.sv @@
`timescale 1ns / 1ps

module sca_cell import sca_pkg::*; #(
  parameter int unsigned CHAN_IDX = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  ctl_t  ctl_i,
  input  link_t link_i,
  output link_t link_o,
  output logic  active_o,
  output logic  freed_o
);

  logic        act_q;
  logic        freed_q;
  logic        sel2_q;
  logic        cand3_q;
  link_t       link_q;
  link_t       link_d;
  logic [7:0]  sound_q;
  logic [7:0]  prio_q;
  logic [15:0] origin_q;
  logic        pickup_q;
  logic [31:0] end_q;

  logic        eval;
  logic        org_eq;
  logic        pk_eq;
  logic [31:0] diff;
  logic        rel1;
  logic        rel2;
  logic        act1;
  logic        take2;
  logic        cand3;
  logic        rel_now;
  logic        take;

  always_comb begin
    eval    = link_i.tok & req_i.en;
    org_eq  = (origin_q == req_i.origin);
    pk_eq   = (pickup_q == req_i.pickup);
    diff    = end_q - ctl_i.tick;
    rel1    = 1'b0;
    rel2    = 1'b0;
    act1    = act_q;
    take2   = 1'b0;
    cand3   = 1'b0;
    rel_now = 1'b0;
    link_d  = link_i;
    if (eval) begin
      case (req_i.op)
        OP_START: begin
          // drop the earlier sound of this origin and class
          rel1 = !link_i.hit1 && act_q && org_eq && pk_eq;
          act1 = act_q && !rel1;
          // first free channel, or a matching busy one ahead of it
          if (!link_i.hit2) begin
            if (!act1) begin
              take2 = 1'b1;
            end else if ((req_i.origin != 16'd0) && org_eq && pk_eq) begin
              take2 = 1'b1;
              rel2  = 1'b1;
            end
          end
          // steal candidate, used only when every channel stays busy
          cand3   = !link_i.hit3 && (prio_q >= req_i.prio);
          rel_now = rel1 | rel2;
        end
        OP_STOP: begin
          rel1    = !link_i.hit1 && act_q && org_eq;
          rel_now = rel1;
        end
        OP_TICK: begin
          rel_now = act_q && diff[31];
        end
        OP_STOP_ALL: begin
          rel_now = act_q;
        end
        default: begin
          rel_now = 1'b0;
        end
      endcase
    end
    link_d.hit1 = link_i.hit1 | rel1;
    link_d.hit2 = link_i.hit2 | take2;
    link_d.hit3 = link_i.hit3 | cand3;
    link_d.idx2 = take2 ? ChanIdxW'(CHAN_IDX) : link_i.idx2;
    link_d.idx3 = cand3 ? ChanIdxW'(CHAN_IDX) : link_i.idx3;
    take        = ctl_i.commit & (ctl_i.use_free ? sel2_q : cand3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      freed_q <= 1'b0;
      sel2_q  <= 1'b0;
      cand3_q <= 1'b0;
      link_q  <= '0;
    end else begin
      link_q <= link_d;
      if (ctl_i.clr) begin
        freed_q <= 1'b0;
        sel2_q  <= 1'b0;
        cand3_q <= 1'b0;
      end
      if (eval && (req_i.op == OP_START)) begin
        sel2_q  <= take2;
        cand3_q <= cand3;
      end
      if (rel_now) begin
        act_q   <= 1'b0;
        freed_q <= 1'b1;
      end
      if (take) begin
        act_q <= 1'b1;
        // stolen channel counts as freed
        if (act_q) begin
          freed_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rel_now) begin
      end_q <= 32'd0;
    end
    if (take) begin
      sound_q  <= req_i.sound;
      origin_q <= req_i.origin;
      pickup_q <= req_i.pickup;
      prio_q   <= req_i.prio;
      end_q    <= ctl_i.tick + 32'(req_i.dur);
    end
  end

  assign link_o   = link_q;
  assign active_o = act_q;
  assign freed_o  = freed_q;

endmodule

@@ bench/sca_request_checker.sv @@
`timescale 1ns / 1ps

module sca_request_checker import sca_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [15:0] origin_id_i,
  input  logic [7:0]  sound_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] duration_i,
  input  logic        is_pickup_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic        granted_i,
  input  logic [2:0]  channel_i,
  input  logic [7:0]  freed_mask_i,
  input  logic [7:0]  active_mask_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  localparam int MaxReports = 100;

  typedef struct packed {
    logic       granted;
    logic [2:0] channel;
    logic [7:0] freed;
    logic [7:0] active;
  } alloc_answer_t;

  alloc_answer_t sound_answers_q[$];
  alloc_answer_t next_answer, seen_answer;

  // own copy of the channel table
  logic        chan_on   [NUM_CHANNELS];
  logic [7:0]  chan_snd  [NUM_CHANNELS];
  logic [15:0] chan_src  [NUM_CHANNELS];
  logic        chan_pick [NUM_CHANNELS];
  logic [7:0]  chan_prio [NUM_CHANNELS];
  logic [31:0] chan_end  [NUM_CHANNELS];
  logic [31:0] tick_now;
  logic        sound_on;
  logic [7:0]  freed_now;

  task automatic free_channel(input int c);
    if (chan_on[c]) begin
      chan_on[c]  = 1'b0;
      chan_end[c] = '0;
      if (c < 8) freed_now[c] = 1'b1;
    end
  endtask

  task automatic serve_sound_request(input op_e op, input logic [15:0] src,
                                     input logic [7:0] snd, input logic [7:0] prio,
                                     input logic [15:0] dur, input logic pick,
                                     output alloc_answer_t answer);
    int take;
    answer    = '0;
    freed_now = '0;
    take      = NUM_CHANNELS;
    if (sound_on) begin
      case (op)
        OP_START: begin
          // same origin and class frees its earlier sound first
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (chan_on[c] && chan_src[c] == src && chan_pick[c] == pick) begin
              free_channel(c);
              break;
            end
          end
          // scan up to the first free channel
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (!chan_on[c]) begin
              take = c;
              break;
            end
            if (src != '0 && chan_src[c] == src && chan_pick[c] == pick) begin
              free_channel(c);
              take = c;
              break;
            end
          end
          // all busy: steal by priority
          if (take == NUM_CHANNELS) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              if (chan_prio[c] >= prio) begin
                free_channel(c);
                take = c;
                break;
              end
            end
          end
          if (take < NUM_CHANNELS) begin
            chan_on[take]   = 1'b1;
            chan_snd[take]  = snd;
            chan_src[take]  = src;
            chan_pick[take] = pick;
            chan_prio[take] = prio;
            chan_end[take]  = tick_now + 32'(dur);
            answer.granted  = 1'b1;
            answer.channel  = 3'(take);
          end
        end
        OP_STOP: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (chan_on[c] && chan_src[c] == src) begin
              free_channel(c);
              break;
            end
          end
        end
        OP_TICK: begin
          tick_now = tick_now + 32'd1;
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (chan_on[c] && (chan_end[c] - tick_now) >= 32'h8000_0000) free_channel(c);
          end
        end
        default: begin
          for (int c = 0; c < NUM_CHANNELS; c++) free_channel(c);
        end
      endcase
    end
    answer.freed = freed_now;
    for (int c = 0; c < NUM_CHANNELS && c < 8; c++) answer.active[c] = chan_on[c];
  endtask

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      if (mismatch_count_o < MaxReports)
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_on[c]   = 1'b0;
        chan_snd[c]  = '0;
        chan_src[c]  = '0;
        chan_pick[c] = 1'b0;
        chan_prio[c] = '0;
        chan_end[c]  = '0;
      end
      tick_now = '0;
      sound_on = 1'b1;
      sound_answers_q.delete();
    end else begin
      // compare before pushing so a stray result cannot match a fresh request
      if (res_valid_i && res_ready_i) begin
        seen_answer = {granted_i, channel_i, freed_mask_i, active_mask_i};
        if (sound_answers_q.size() == 0) begin
          if (mismatch_count_o < MaxReports)
            $display("%0t: result expected none actual %0h", $time, seen_answer);
          mismatch_count_o++;
        end else begin
          next_answer = sound_answers_q.pop_front();
          compare_field("granted", 8'(next_answer.granted), 8'(seen_answer.granted));
          compare_field("channel", 8'(next_answer.channel), 8'(seen_answer.channel));
          compare_field("freed_mask", next_answer.freed, seen_answer.freed);
          compare_field("active_mask", next_answer.active, seen_answer.active);
        end
      end
      if (cfg_valid_i && cfg_ready_i) sound_on = cfg_data_i;
      if (req_valid_i && req_ready_i) begin
        serve_sound_request(op_e'(operation_i), origin_id_i, sound_id_i, priority_req_i,
                            duration_i, is_pickup_i, next_answer);
        sound_answers_q.push_back(next_answer);
      end
    end
    pending_o = sound_answers_q.size();
  end

endmodule

@@ bench/tb_sound_channel_allocator.sv @@
`timescale 1ns / 1ps

module tb_sound_channel_allocator import sca_pkg::*; ();

  localparam int unsigned NumChannels = 8;
  localparam int HalfPeriod = 5;
  // cycles with no request, result or register write before giving up
  localparam int StallLimit = 4000;
  // settling time, waited out once every result is back
  localparam int SettleCycles = 20;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i    = '0;
  logic [15:0] origin_id_i    = '0;
  logic [7:0]  sound_id_i     = 8'd1;
  logic [7:0]  priority_req_i = '0;
  logic [15:0] duration_i     = '0;
  logic        is_pickup_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        granted_o;
  logic [2:0]  channel_o;
  logic [7:0]  freed_mask_o;
  logic [7:0]  active_mask_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i     = 1'b0;

  int mismatch_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  always #HalfPeriod clk_i = ~clk_i;

  sound_channel_allocator #(
    .NUM_CHANNELS(NumChannels)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .origin_id_i   (origin_id_i),
    .sound_id_i    (sound_id_i),
    .priority_req_i(priority_req_i),
    .duration_i    (duration_i),
    .is_pickup_i   (is_pickup_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .granted_o     (granted_o),
    .channel_o     (channel_o),
    .freed_mask_o  (freed_mask_o),
    .active_mask_o (active_mask_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // watches all three channels, keeps its own channel table and compares
  sca_request_checker #(
    .NUM_CHANNELS(NumChannels)
  ) req_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (in_valid_i),
    .req_ready_i     (in_ready_o),
    .operation_i     (operation_i),
    .origin_id_i     (origin_id_i),
    .sound_id_i      (sound_id_i),
    .priority_req_i  (priority_req_i),
    .duration_i      (duration_i),
    .is_pickup_i     (is_pickup_i),
    .res_valid_i     (out_valid_o),
    .res_ready_i     (out_ready_i),
    .granted_i       (granted_o),
    .channel_i       (channel_o),
    .freed_mask_i    (freed_mask_o),
    .active_mask_i   (active_mask_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  // receiver side: ready drops at random, at the rate of the current phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog: restarts on any handshake, otherwise counts up to the limit
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request: optional idle cycles, then valid held until accepted;
  // returns at the accepting edge so the next request can follow back to back
  task automatic send_request(input op_e op, input logic [15:0] src, input logic [7:0] snd,
                              input logic [7:0] prio, input logic [15:0] dur,
                              input logic pick);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    origin_id_i    <= src;
    sound_id_i     <= snd;
    priority_req_i <= prio;
    duration_i     <= dur;
    is_pickup_i    <= pick;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // mostly starts and ticks over a small origin pool so that replacement,
  // stealing and expiry keep happening; wide values now and then
  task automatic send_random_request();
    int unsigned roll;
    op_e         op;
    logic [15:0] src;
    logic [15:0] dur;
    logic [7:0]  prio;
    roll = $urandom_range(0, 99);
    if (roll < 50) op = OP_START;
    else if (roll < 80) op = OP_TICK;
    else if (roll < 96) op = OP_STOP;
    else op = OP_STOP_ALL;
    src  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    prio = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
    dur  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    send_request(op, src, 8'($urandom_range(1, 255)), prio, dur, 1'($urandom));
  endtask

  // stop sending and wait for every outstanding result; sampled at the
  // falling edge so the checker's count has settled
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // sound_enable write, only issued with the block idle
  task automatic write_sound_enable(input logic enable);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= enable;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase one: sender idles a little, receiver stalls a lot
    send_idle_pct = 20;
    recv_idle_pct = 81;
    write_sound_enable(1'b1);

    // origin 0 on its own, then replaced by itself (freed and retaken)
    send_request(OP_START, 16'h0000, 8'd1, 8'd0, 16'd0, 1'b0);
    send_request(OP_START, 16'h0000, 8'd2, 8'd0, 16'd3, 1'b0);
    // widest origin in both pickup classes, then the pickup slot replaced
    send_request(OP_START, 16'hffff, 8'd255, 8'd255, 16'hffff, 1'b1);
    send_request(OP_START, 16'hffff, 8'd128, 8'd128, 16'd5, 1'b0);
    send_request(OP_START, 16'hffff, 8'd7, 8'd200, 16'd2, 1'b1);
    // fill the remaining channels
    for (int i = 1; i <= 5; i++)
      send_request(OP_START, 16'(i), 8'(i + 10), 8'(i + 10), 16'(i), 1'b0);
    // all busy: nothing low enough to steal, then a steal by priority
    send_request(OP_START, 16'h0009, 8'd40, 8'd255, 16'd4, 1'b0);
    send_request(OP_START, 16'h0009, 8'd41, 8'd12, 16'd4, 1'b0);
    // all busy but the origin is already playing: replaced in place
    send_request(OP_START, 16'h0003, 8'd42, 8'd250, 16'd1, 1'b0);
    // stop by origin: a hit, a miss, and the listener
    send_request(OP_STOP, 16'h0004, 8'd1, 8'd0, 16'd0, 1'b0);
    send_request(OP_STOP, 16'habcd, 8'd1, 8'd0, 16'd0, 1'b1);
    send_request(OP_STOP, 16'h0000, 8'd1, 8'd0, 16'd0, 1'b0);
    // ticks expire the short sounds one after another
    repeat (4) send_request(OP_TICK, 16'h5a5a, 8'd170, 8'd85, 16'ha5a5, 1'b1);
    send_request(OP_START, 16'h0000, 8'd99, 8'd77, 16'd0, 1'b1);
    send_request(OP_TICK, 16'h0000, 8'd1, 8'd0, 16'd0, 1'b0);
    // stop all with channels busy, then with nothing left
    send_request(OP_STOP_ALL, 16'h1234, 8'd3, 8'd3, 16'd3, 1'b0);
    send_request(OP_STOP_ALL, 16'h0000, 8'd1, 8'd0, 16'd0, 1'b0);

    repeat (500) send_random_request();
    drain_requests();

    // sound disabled: every request answered, nothing changes
    write_sound_enable(1'b0);
    repeat (40) send_random_request();
    drain_requests();
    write_sound_enable(1'b1);

    // phase two: the other way round
    send_idle_pct = 81;
    recv_idle_pct = 20;
    repeat (500) send_random_request();
    drain_requests();
    write_sound_enable(1'b0);
    repeat (20) send_random_request();
    drain_requests();
    write_sound_enable(1'b1);

    // phase three: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (550) send_random_request();
    drain_requests();

    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
